// File: src/pse_pkg.sv
// shared codes for the pair sum enumerator
// request codes and configuration register indexes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

	// request codes carried by req_type
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// configuration register indexes
	localparam int unsigned REG_TARGET_SUM = 0;

endpackage

`default_nettype wire

// File: src/pair_sum_enumerator.sv
// pair sum enumerator top level: element store, insertion sequencer and pair scanner
// depends on pse_pkg for request codes and register indexes
// busy: a load holds busy through ST_INS_CHK and ST_INS_WAIT for each of the k elements
//   moved up and for the final write; a fetch holds it per pair tested, row opened, row
//   stepped past and the exhausted check; full-store loads and unsorted fetches are never busy
// flow: one transaction at a time, the next accepted in any cycle in which busy is low;
//   a fetch result is a one cycle strobe that the receiver cannot stall
// reset: empty unsorted set, target sum 0, store contents undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module pair_sum_enumerator
	import pse_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_BITS   = 32,
	localparam int DATA_W      = (VALUE_BITS > 32) ? 64 : 32,
	localparam int ALIGN       = (VALUE_BITS > 32) ? 3 : 2,
	localparam int ADDR_W      = ALIGN + 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// command channel
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         req_type,
	input  wire logic signed [VALUE_BITS-1:0] element_value,
	input  wire logic                         last_element,
	// result channel
	output logic                              result_valid,
	output logic                              pair_valid,
	output logic signed [VALUE_BITS-1:0]      pair_smaller,
	output logic signed [VALUE_BITS-1:0]      pair_larger,
	output logic                              input_dropped,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ADDR_W-1:0]            paddr,
	input  wire logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]                 prdata,
	output logic                              pready
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int SW = VALUE_BITS + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_WAIT,
		ST_SCAN_CHK,
		ST_SCAN_A,
		ST_SCAN_B
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic                    sorted_q;
	logic                    dropped_q;
	logic [CW-1:0]           first_q;
	logic [CW-1:0]           second_q;
	logic [CW-1:0]           j_q;
	logic                    last_q;
	logic                    a_ok_q;
	logic [VALUE_BITS-1:0]   v_q;
	logic [VALUE_BITS-1:0]   a_q;
	logic [VALUE_BITS-1:0]   rd_q;
	logic [VALUE_BITS-1:0]   target_q;

	logic [VALUE_BITS-1:0]   mem [MAX_ELEMENTS];
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [VALUE_BITS-1:0]   mem_wdata;
	logic [AW-1:0]           mem_raddr;

	logic                    accept;
	logic                    cfg_wr;
	logic                    reg_hit;
	logic [CW-1:0]           j_m1;
	logic [CW-1:0]           eff_count;
	logic                    v_less;
	logic [SW-1:0]           pair_sum;
	logic                    sum_match;

	// configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:ALIGN] == 1'(REG_TARGET_SUM));
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = reg_hit ? DATA_W'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr && reg_hit) begin
			target_q <= pwdata[VALUE_BITS-1:0];
		end
	end

	// compare unit for insertion and add unit for the pair scan
	assign v_less    = $signed(v_q) < $signed(rd_q);
	assign pair_sum  = {a_q[VALUE_BITS-1], a_q} + {rd_q[VALUE_BITS-1], rd_q};
	assign sum_match = (pair_sum == {target_q[VALUE_BITS-1], target_q});

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign j_m1      = j_q - 1'b1;
	assign eff_count = sorted_q ? '0 : count_q;

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q[AW-1:0];
		mem_wdata = v_q;
		mem_raddr = j_m1[AW-1:0];
		unique case (state_q)
			ST_INS_CHK: begin
				if (j_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_INS_WAIT: begin
				mem_we    = 1'b1;
				mem_wdata = v_less ? rd_q : v_q;
			end
			ST_SCAN_CHK: begin
				mem_raddr = a_ok_q ? second_q[AW-1:0] : first_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// element store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// sequencer, set state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			sorted_q      <= 1'b0;
			dropped_q     <= 1'b0;
			first_q       <= '0;
			second_q      <= CW'(1);
			j_q           <= '0;
			last_q        <= 1'b0;
			a_ok_q        <= 1'b0;
			v_q           <= '0;
			a_q           <= '0;
			result_valid  <= 1'b0;
			pair_valid    <= 1'b0;
			pair_smaller  <= '0;
			pair_larger   <= '0;
			input_dropped <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == REQ_LOAD) begin
						a_ok_q <= 1'b0;
						// a load after sorting opens a new set
						if (sorted_q) begin
							sorted_q  <= 1'b0;
							dropped_q <= 1'b0;
							first_q   <= '0;
							second_q  <= CW'(1);
						end
						count_q <= eff_count;
						if (eff_count < CW'(MAX_ELEMENTS)) begin
							j_q     <= eff_count;
							v_q     <= element_value;
							last_q  <= last_element;
							state_q <= ST_INS_CHK;
						end else begin
							// store full: drop, but a last mark still closes the set
							dropped_q <= 1'b1;
							if (last_element) begin
								sorted_q <= 1'b1;
								first_q  <= '0;
								second_q <= CW'(1);
							end
						end
					end else if (accept) begin
						input_dropped <= dropped_q;
						pair_smaller  <= '0;
						pair_larger   <= '0;
						pair_valid    <= 1'b0;
						if (sorted_q) begin
							state_q <= ST_SCAN_CHK;
						end else begin
							result_valid <= 1'b1;
						end
					end
				end
				ST_INS_CHK: begin
					if (j_q == '0) begin
						count_q <= count_q + 1'b1;
						if (last_q) begin
							sorted_q <= 1'b1;
							first_q  <= '0;
							second_q <= CW'(1);
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_INS_WAIT;
					end
				end
				ST_INS_WAIT: begin
					// shift the larger neighbor up, or drop the new value in place
					if (v_less) begin
						j_q     <= j_m1;
						state_q <= ST_INS_CHK;
					end else begin
						count_q <= count_q + 1'b1;
						if (last_q) begin
							sorted_q <= 1'b1;
							first_q  <= '0;
							second_q <= CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN_CHK: begin
					if (first_q >= count_q) begin
						// pairs exhausted
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end else if (second_q >= count_q) begin
						first_q  <= first_q + 1'b1;
						second_q <= first_q + CW'(2);
						a_ok_q   <= 1'b0;
					end else if (!a_ok_q) begin
						state_q <= ST_SCAN_A;
					end else begin
						state_q <= ST_SCAN_B;
					end
				end
				ST_SCAN_A: begin
					a_q     <= rd_q;
					a_ok_q  <= 1'b1;
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_B: begin
					second_q <= second_q + 1'b1;
					if (sum_match) begin
						result_valid <= 1'b1;
						pair_valid   <= 1'b1;
						pair_smaller <= a_q;
						pair_larger  <= rd_q;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for pair_sum_enumerator: directed and random load/fetch traffic,
// target sum writes over the APB port, results checked against an in-bench pair predictor
// depends on pse_pkg and the pair_sum_enumerator RTL
module testbench;
	import pse_pkg::*;

	localparam int MAX_ELEMENTS   = 64;
	localparam int VALUE_BITS     = 32;
	localparam int ADDR_W         = 3;
	localparam int SETTLE_CYCLES  = 2 * MAX_ELEMENTS + 8;
	localparam int RANDOM_ITEMS   = 1000;
	localparam longint CYCLE_LIMIT = 8000000;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	typedef struct {
		logic   found;
		value_t smaller;
		value_t larger;
		logic   dropped;
	} pair_result_t;

	localparam value_t VAL_MIN = value_t'(32'h8000_0000);
	localparam value_t VAL_MAX = value_t'(32'h7fff_ffff);

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	value_t element_value;
	logic last_element;
	logic result_valid;
	logic pair_valid;
	value_t pair_smaller;
	value_t pair_larger;
	logic input_dropped;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// predictor state: mirror of the element set and the pair cursor
	value_t set_vals [MAX_ELEMENTS];
	int     set_len = 0;
	logic   set_closed = 1'b0;
	int     row_idx = 0;
	int     col_idx = 1;
	logic   set_overflowed = 1'b0;
	value_t target_val = '0;

	pair_result_t pair_q[$];
	int     mismatch_count = 0;
	int     items_sent = 0;
	int     burst_left = 0;
	longint cycle_count = 0;

	pair_sum_enumerator #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.element_value(element_value),
		.last_element(last_element),
		.result_valid(result_valid),
		.pair_valid(pair_valid),
		.pair_smaller(pair_smaller),
		.pair_larger(pair_larger),
		.input_dropped(input_dropped),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// exact sum in 64-bit longint arithmetic, never wrapped
	function automatic logic sum_hits(value_t a, value_t b);
		return (longint'(a) + longint'(b)) == longint'(target_val);
	endfunction

	// matching pairs in the closed set, used to size the fetch runs
	function automatic int count_pairs();
		int n;
		n = 0;
		if (!set_closed)
			return 0;
		for (int i = 0; i < set_len; i++)
			for (int j = i + 1; j < set_len; j++)
				if (sum_hits(set_vals[i], set_vals[j]))
					n++;
		return n;
	endfunction

	// advance the predicted enumerator by one accepted transaction
	task automatic step_enumerator(logic rt, value_t v, logic last);
		int j;
		value_t key;
		pair_result_t r;
		if (rt == REQ_LOAD) begin
			// a load on a closed set opens a new one
			if (set_closed) begin
				set_len = 0;
				set_closed = 1'b0;
				row_idx = 0;
				col_idx = 1;
				set_overflowed = 1'b0;
			end
			if (set_len < MAX_ELEMENTS) begin
				set_vals[set_len] = v;
				set_len++;
			end else begin
				set_overflowed = 1'b1;
			end
			// closing mark sorts ascending, even on a dropped element
			if (last) begin
				for (int i = 1; i < set_len; i++) begin
					key = set_vals[i];
					j = i;
					while (j > 0 && key < set_vals[j-1]) begin
						set_vals[j] = set_vals[j-1];
						j--;
					end
					set_vals[j] = key;
				end
				set_closed = 1'b1;
				row_idx = 0;
				col_idx = 1;
			end
			return;
		end
		// fetch: next pair in index order, or not-valid with zero values
		r.found = 1'b0;
		r.smaller = '0;
		r.larger = '0;
		r.dropped = set_overflowed;
		if (set_closed) begin
			while (row_idx < set_len && !r.found) begin
				while (col_idx < set_len && !r.found) begin
					if (sum_hits(set_vals[row_idx], set_vals[col_idx])) begin
						r.found = 1'b1;
						r.smaller = set_vals[row_idx];
						r.larger = set_vals[col_idx];
					end
					col_idx++;
				end
				if (!r.found) begin
					row_idx++;
					col_idx = row_idx + 1;
				end
			end
		end
		pair_q.insert(pair_q.size(), r);
	endtask

	task automatic flag_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n && result_valid) begin
			if (pair_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result valid=%0b smaller=%0d larger=%0d dropped=%0b",
					pair_valid, pair_smaller, pair_larger, input_dropped));
			end else begin
				want = pair_q.pop_front();
				if (pair_valid !== want.found || pair_smaller !== want.smaller ||
				    pair_larger !== want.larger || input_dropped !== want.dropped)
					flag_mismatch($sformatf({"expected valid=%0b smaller=%0d larger=%0d dropped=%0b,",
						" got valid=%0b smaller=%0d larger=%0d dropped=%0b"},
						want.found, want.smaller, want.larger, want.dropped,
						pair_valid, pair_smaller, pair_larger, input_dropped));
			end
		end
	end

	// one transaction on the command port; entered and left at a falling edge
	task automatic issue_request(logic rt, value_t v, logic last);
		// sender bursts with random gaps
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start = 1'b1;
		req_type = rt;
		element_value = v;
		last_element = last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		step_enumerator(rt, v, last);
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	// wait for every expected result, then for the block to go quiet
	task automatic settle();
		while (pair_q.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// target sum write, then read back
	task automatic write_target(value_t t);
		settle();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_W'(REG_TARGET_SUM * 4);
		pwdata = t;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		target_val = t;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== 32'(t))
			flag_mismatch($sformatf("target read back expected %0d, got %0d", t, $signed(prdata)));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic fetch_pairs(int n);
		repeat (n) issue_request(REQ_FETCH, $urandom, 1'($urandom_range(0, 1)));
	endtask

	// fetch right after reset: nothing loaded, not-valid every time
	task automatic test_fetch_before_load();
		fetch_pairs(2);
	endtask

	// extreme values: exact sums must not wrap
	task automatic test_sum_extremes();
		write_target(-1);
		issue_request(REQ_LOAD, VAL_MAX, 1'b0);
		issue_request(REQ_LOAD, VAL_MIN, 1'b1);
		fetch_pairs(2);
		write_target(-2);
		issue_request(REQ_LOAD, VAL_MAX, 1'b0);
		issue_request(REQ_LOAD, VAL_MAX, 1'b1);
		fetch_pairs(1);
		write_target(VAL_MIN);
		issue_request(REQ_LOAD, VAL_MIN, 1'b0);
		issue_request(REQ_LOAD, 0, 1'b0);
		issue_request(REQ_LOAD, VAL_MIN, 1'b1);
		fetch_pairs(3);
		write_target(VAL_MAX);
		issue_request(REQ_LOAD, 0, 1'b0);
		issue_request(REQ_LOAD, VAL_MAX, 1'b1);
		fetch_pairs(2);
	endtask

	// equal values give repeated pairs
	task automatic test_repeated_values();
		write_target(10);
		issue_request(REQ_LOAD, 5, 1'b0);
		issue_request(REQ_LOAD, 5, 1'b0);
		issue_request(REQ_LOAD, 5, 1'b1);
		fetch_pairs(4);
	endtask

	// single element set and a fetch in the middle of loading
	task automatic test_tiny_and_open_sets();
		issue_request(REQ_LOAD, 5, 1'b1);
		fetch_pairs(2);
		issue_request(REQ_LOAD, 7, 1'b0);
		issue_request(REQ_LOAD, 3, 1'b0);
		fetch_pairs(1);
		issue_request(REQ_LOAD, 2, 1'b1);
		fetch_pairs(2);
	endtask

	// full store: extra loads dropped and flagged, the closing mark on a dropped one
	// still sorts; the next set clears the flag
	task automatic test_store_full();
		write_target(3);
		for (int i = MAX_ELEMENTS + 1; i >= 0; i--)
			issue_request(REQ_LOAD, i, i == 0);
		fetch_pairs(3);
		issue_request(REQ_LOAD, 2, 1'b0);
		issue_request(REQ_LOAD, 1, 1'b1);
		fetch_pairs(2);
	endtask

	// random sets: mostly well-formed with matching pairs, some noise
	task automatic test_random_sets();
		value_t vals [72];
		value_t pool [7];
		int first_item;
		int size;
		int mode;
		int npairs;
		int nfetch;
		int p;
		int q;
		int k;
		int n;
		longint s;
		logic open_set;
		pool = '{VAL_MIN, VAL_MIN + 1, -1, 0, 1, VAL_MAX - 1, VAL_MAX};
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			// mostly small sets, a few near or past capacity
			k = $urandom_range(0, 99);
			if (k < 78)
				size = $urandom_range(2, 10);
			else if (k < 86)
				size = 1;
			else if (k < 96)
				size = $urandom_range(11, 40);
			else
				size = $urandom_range(60, 70);
			mode = $urandom_range(0, 2);
			for (n = 0; n < size; n++) begin
				case (mode)
					0: vals[n] = int'($urandom_range(0, 12)) - 6;
					1: vals[n] = $urandom;
					default: vals[n] = pool[$urandom_range(0, 6)];
				endcase
			end
			// new target on most sets: two members' sum if it fits, small random for small values
			if ($urandom_range(0, 2) != 0) begin
				p = $urandom_range(0, size - 1);
				q = $urandom_range(0, size - 1);
				if (mode == 0)
					s = longint'(int'($urandom_range(0, 16)) - 8);
				else
					s = longint'(vals[p]) + longint'(vals[q]);
				if (s < longint'(VAL_MIN) || s > longint'(VAL_MAX))
					s = longint'(value_t'($urandom));
				write_target(value_t'(s));
			end
			open_set = ($urandom_range(0, 9) == 0);
			for (n = 0; n < size; n++) begin
				if ($urandom_range(0, 9) == 0)
					fetch_pairs(1);
				issue_request(REQ_LOAD, vals[n], !open_set && n == size - 1);
			end
			npairs = count_pairs();
			if (open_set)
				nfetch = $urandom_range(1, 2);
			else if ($urandom_range(0, 6) == 0)
				nfetch = $urandom_range(0, npairs);
			else
				nfetch = npairs + $urandom_range(1, 2);
			if (nfetch > 60)
				nfetch = 60;
			fetch_pairs(nfetch);
			// occasional hold until every result is back
			if ($urandom_range(0, 9) == 0)
				settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_LOAD;
		element_value = '0;
		last_element = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fetch_before_load();
		test_sum_extremes();
		test_repeated_values();
		test_tiny_and_open_sets();
		test_store_full();
		test_random_sets();

		settle();
		if (mismatch_count == 0 && pair_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count, pair_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
